/* hw/rtl/gns_pkg.sv */
// shared types and constants for the 2d gradient noise sampler
// used by every module of the block; depends on nothing

package gns_pkg;

  localparam int CELL_W  = 7;
  localparam int GRAD_W  = 16;
  localparam int ENTRY_W = 2 * GRAD_W;
  localparam int POS_W   = 23;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 8;
  localparam int SIDE_W  = 9;
  localparam int NOISE_W = 16;

  // datapath widths
  localparam int OFS_W  = FRAC_W + 1;
  localparam int PROD_W = GRAD_W + OFS_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int DIFF_W = DOT_W + 1;
  localparam int MX_W   = DIFF_W + OFS_W;
  localparam int SUMX_W = MX_W + 1;
  localparam int VX_W   = SUMX_W - FRAC_W;
  localparam int DY_W   = VX_W + 1;
  localparam int MY_W   = DY_W + OFS_W;
  localparam int SUMY_W = MY_W + 1;
  localparam int R_W    = SUMY_W - 2 * FRAC_W;

  localparam int PIPE_DEPTH = 8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic [CFG_W-1:0] GRID_SIDE_RESET = CFG_W'(128);

  typedef enum logic [1:0] {
    ST_WRITE_DONE  = 2'd0,
    ST_NOISE       = 2'd1,
    ST_OUT_OF_GRID = 2'd2
  } status_e;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic              x_odd;
    logic              y_odd;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } ctrl_t;

endpackage

/* hw/rtl/gradient_noise_sampler_2d.sv */
// 2d gradient noise sampler: gradient table writes and linear-blend noise evaluation
// one item per cycle unless a valid result is stalled at the output
// an output stall freezes the whole pipeline, so nothing is dropped or repeated
// reset clears the stage valid bits and sets grid_side to 128
// the gradient table is not cleared by reset and reads as undefined until written
// depends on gns_pkg, gns_grad_banks, gns_corner_dot, gns_blend

module gradient_noise_sampler_2d import gns_pkg::*; #(
  parameter int GRID_SIDE = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [CELL_W-1:0]          cell_x_i,
  input  logic [CELL_W-1:0]          cell_y_i,
  input  logic signed [GRAD_W-1:0]   grad_x_i,
  input  logic signed [GRAD_W-1:0]   grad_y_i,
  input  logic [POS_W-1:0]           pos_x_i,
  input  logic [POS_W-1:0]           pos_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic signed [NOISE_W-1:0]  noise_o
);

  localparam logic [SIDE_W-1:0] GRID_SIDE_L = SIDE_W'(GRID_SIDE);

  logic [CFG_W-1:0]         grid_side_q;
  logic [SIDE_W-1:0]        side_eff;
  logic                     en;
  logic                     in_xfer;
  logic                     wr_ok, eval_ok;
  logic                     mem_wr_en, mem_rd_en;
  logic [CELL_W-1:0]        x0, y0;
  status_e                  status_d;
  ctrl_t                    ctrl_d;
  ctrl_t                    ctrl_q [PIPE_DEPTH];
  logic [3:0][ENTRY_W-1:0]  rd_data;
  logic signed [DOT_W-1:0]  v1, v3;
  logic signed [DIFF_W-1:0] d21, d43;
  logic signed [NOISE_W-1:0] noise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RESET;
    end else if (cfg_we_i) begin
      grid_side_q <= cfg_wdata_i;
    end
  end

  assign side_eff = (SIDE_W'(grid_side_q) > GRID_SIDE_L) ? GRID_SIDE_L
                                                         : SIDE_W'(grid_side_q);

  // whole pipeline advances unless the result register is stalled
  assign en         = !(ctrl_q[PIPE_DEPTH-1].valid && out_stall_i);
  assign in_stall_o = !en;
  assign in_xfer    = in_valid_i && en;

  assign x0 = pos_x_i[POS_W-1:FRAC_W];
  assign y0 = pos_y_i[POS_W-1:FRAC_W];

  assign wr_ok   = (SIDE_W'(cell_x_i) < side_eff) && (SIDE_W'(cell_y_i) < side_eff);
  assign eval_ok = (SIDE_W'(x0) + SIDE_W'(1) < side_eff)
                && (SIDE_W'(y0) + SIDE_W'(1) < side_eff);

  always_comb begin
    if (action_i == ACT_WRITE) begin
      status_d = wr_ok ? ST_WRITE_DONE : ST_OUT_OF_GRID;
    end else begin
      status_d = eval_ok ? ST_NOISE : ST_OUT_OF_GRID;
    end
  end

  assign mem_wr_en = in_xfer && (action_i == ACT_WRITE) && wr_ok;
  assign mem_rd_en = in_xfer && (action_i == ACT_EVAL) && eval_ok;

  always_comb begin
    ctrl_d.valid  = in_valid_i;
    ctrl_d.status = status_d;
    ctrl_d.x_odd  = x0[0];
    ctrl_d.y_odd  = y0[0];
    ctrl_d.fx     = pos_x_i[FRAC_W-1:0];
    ctrl_d.fy     = pos_y_i[FRAC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        ctrl_q[i] <= '0;
      end
    end else if (en) begin
      ctrl_q[0] <= ctrl_d;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
    end
  end

  gns_grad_banks #(
    .GRID_SIDE (GRID_SIDE)
  ) u_banks (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_x_i    (cell_x_i),
    .wr_y_i    (cell_y_i),
    .wr_data_i ({grad_y_i, grad_x_i}),
    .rd_en_i   (mem_rd_en),
    .rd_x_i    (x0),
    .rd_y_i    (y0),
    .rd_data_o (rd_data)
  );

  gns_corner_dot u_dot (
    .clk_i     (clk_i),
    .en_i      (en),
    .ctrl_i    (ctrl_q[0]),
    .rd_data_i (rd_data),
    .v1_o      (v1),
    .v3_o      (v3),
    .d21_o     (d21),
    .d43_o     (d43)
  );

  gns_blend u_blend (
    .clk_i   (clk_i),
    .en_i    (en),
    .fx_i    (ctrl_q[2].fx),
    .fy_i    (ctrl_q[5].fy),
    .v1_i    (v1),
    .v3_i    (v3),
    .d21_i   (d21),
    .d43_i   (d43),
    .noise_o (noise)
  );

  assign out_valid_o = ctrl_q[PIPE_DEPTH-1].valid;
  assign status_o    = ctrl_q[PIPE_DEPTH-1].status;
  assign noise_o     = (ctrl_q[PIPE_DEPTH-1].status == ST_NOISE) ? noise : '0;

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result is stalled");

  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !in_valid_i |=> !ctrl_q[0].valid)
    else $error("bubble entered pipeline as valid item");

  a_wr_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |=> ctrl_q[0].valid && (ctrl_q[0].status == ST_WRITE_DONE))
    else $error("table write without write-done status");

  a_rd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd_en |=> ctrl_q[0].valid && (ctrl_q[0].status == ST_NOISE))
    else $error("corner read without noise status");

endmodule

/* hw/rtl/gns_grad_banks.sv */
// gradient table split into four banks by column and row parity
// one write and four corner reads per cycle, read data registered; uses gns_pkg

module gns_grad_banks import gns_pkg::*; #(
  parameter int GRID_SIDE = 128
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [CELL_W-1:0]         wr_x_i,
  input  logic [CELL_W-1:0]         wr_y_i,
  input  logic [ENTRY_W-1:0]        wr_data_i,
  input  logic                      rd_en_i,
  input  logic [CELL_W-1:0]         rd_x_i,
  input  logic [CELL_W-1:0]         rd_y_i,
  output logic [3:0][ENTRY_W-1:0]   rd_data_o
);

  localparam int HALF  = (GRID_SIDE + 1) / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [15:0] HALF_L = 16'(HALF);

  function automatic logic [AW-1:0] bank_addr(input logic [CELL_W-1:0] row,
                                               input logic [CELL_W-1:0] col);
    logic [15:0] full;
    full = 16'(row) * HALF_L + 16'(col);
    return full[AW-1:0];
  endfunction

  logic [1:0]        wr_bank;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] col_even, col_odd, row_even, row_odd;
  logic [CELL_W:0]   x_inc, y_inc;

  assign wr_bank = {wr_y_i[0], wr_x_i[0]};
  assign wr_addr = bank_addr(wr_y_i >> 1, wr_x_i >> 1);

  // the corner column of even parity is x0 or x0+1, both map to (x0+1)/2
  assign x_inc    = {1'b0, rd_x_i} + (CELL_W+1)'(1);
  assign y_inc    = {1'b0, rd_y_i} + (CELL_W+1)'(1);
  assign col_even = x_inc[CELL_W:1];
  assign col_odd  = rd_x_i >> 1;
  assign row_even = y_inc[CELL_W:1];
  assign row_odd  = rd_y_i >> 1;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int BX = b % 2;
    localparam int BY = b / 2;

    logic [ENTRY_W-1:0] mem_q [DEPTH];
    logic [ENTRY_W-1:0] rd_q;
    logic [AW-1:0]      rd_addr;

    assign rd_addr = bank_addr((BY == 1) ? row_odd : row_even,
                               (BX == 1) ? col_odd : col_even);

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank == 2'(b))) begin
        mem_q[wr_addr] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= mem_q[rd_addr];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

/* hw/rtl/gns_corner_dot.sv */
// corner gradient selection and dot products with the corner offsets
// two register stages: products, then dot sums and x differences; uses gns_pkg

module gns_corner_dot import gns_pkg::*; (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  ctrl_t                            ctrl_i,
  input  logic [3:0][ENTRY_W-1:0]          rd_data_i,
  output logic signed [DOT_W-1:0]          v1_o,
  output logic signed [DOT_W-1:0]          v3_o,
  output logic signed [DIFF_W-1:0]         d21_o,
  output logic signed [DIFF_W-1:0]         d43_o
);

  logic signed [GRAD_W-1:0] gx [4];
  logic signed [GRAD_W-1:0] gy [4];
  logic signed [OFS_W-1:0]  dx [4];
  logic signed [OFS_W-1:0]  dy [4];
  logic signed [PROD_W-1:0] prod_x_q [4];
  logic signed [PROD_W-1:0] prod_y_q [4];
  logic signed [DOT_W-1:0]  dot [4];
  logic signed [DOT_W-1:0]  v1_q, v3_q;
  logic signed [DIFF_W-1:0] d21_q, d43_q;

  // corner order: (x0,y0), (x0+1,y0), (x0,y0+1), (x0+1,y0+1)
  always_comb begin
    logic [1:0]         sel;
    logic [ENTRY_W-1:0] entry;
    for (int c = 0; c < 4; c++) begin
      sel   = {ctrl_i.y_odd ^ c[1], ctrl_i.x_odd ^ c[0]};
      entry = rd_data_i[sel];
      gx[c] = signed'(entry[GRAD_W-1:0]);
      gy[c] = signed'(entry[ENTRY_W-1:GRAD_W]);
      dx[c] = signed'({c[0], ctrl_i.fx});
      dy[c] = signed'({c[1], ctrl_i.fy});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        prod_x_q[c] <= gx[c] * dx[c];
        prod_y_q[c] <= gy[c] * dy[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dot[c] = DOT_W'(prod_x_q[c]) + DOT_W'(prod_y_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q  <= dot[0];
      v3_q  <= dot[2];
      d21_q <= DIFF_W'(dot[1]) - DIFF_W'(dot[0]);
      d43_q <= DIFF_W'(dot[3]) - DIFF_W'(dot[2]);
    end
  end

  assign v1_o  = v1_q;
  assign v3_o  = v3_q;
  assign d21_o = d21_q;
  assign d43_o = d43_q;

endmodule

/* hw/rtl/gns_blend.sv */
// linear blend along x then y with round to nearest and saturation
// five register stages, at most one multiply deep per stage; uses gns_pkg

module gns_blend import gns_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [FRAC_W-1:0]           fx_i,
  input  logic [FRAC_W-1:0]           fy_i,
  input  logic signed [DOT_W-1:0]     v1_i,
  input  logic signed [DOT_W-1:0]     v3_i,
  input  logic signed [DIFF_W-1:0]    d21_i,
  input  logic signed [DIFF_W-1:0]    d43_i,
  output logic signed [NOISE_W-1:0]   noise_o
);

  localparam logic signed [SUMX_W-1:0] RND_X = SUMX_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUMY_W-1:0] RND_Y = SUMY_W'(1) <<< (2 * FRAC_W - 1);
  localparam logic signed [R_W-1:0] NOISE_MAX = R_W'((1 <<< (NOISE_W - 1)) - 1);
  localparam logic signed [R_W-1:0] NOISE_MIN = R_W'(-(1 <<< (NOISE_W - 1)));

  logic signed [OFS_W-1:0]   fx_s, fy_s;
  logic signed [MX_W-1:0]    mx12_q, mx34_q;
  logic signed [DOT_W-1:0]   v1_q, v3_q;
  logic signed [SUMX_W-1:0]  sum12, sum34;
  logic signed [VX_W-1:0]    v12_q, v34_q, v12_s6_q, v12_s7_q;
  logic signed [DY_W-1:0]    dy_q;
  logic signed [MY_W-1:0]    my_q;
  logic signed [SUMY_W-1:0]  sumy;
  logic signed [R_W-1:0]     r;
  logic signed [NOISE_W-1:0] noise_d, noise_q;

  assign fx_s = signed'({1'b0, fx_i});
  assign fy_s = signed'({1'b0, fy_i});

  // x blend products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx12_q <= d21_i * fx_s;
      mx34_q <= d43_i * fx_s;
      v1_q   <= v1_i;
      v3_q   <= v3_i;
    end
  end

  assign sum12 = (SUMX_W'(v1_q) <<< FRAC_W) + SUMX_W'(mx12_q) + RND_X;
  assign sum34 = (SUMX_W'(v3_q) <<< FRAC_W) + SUMX_W'(mx34_q) + RND_X;

  // x blend rounded back to 16 fraction bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v12_q <= VX_W'(sum12 >>> FRAC_W);
      v34_q <= VX_W'(sum34 >>> FRAC_W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dy_q     <= DY_W'(v34_q) - DY_W'(v12_q);
      v12_s6_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      my_q     <= dy_q * fy_s;
      v12_s7_q <= v12_s6_q;
    end
  end

  assign sumy = (SUMY_W'(v12_s7_q) <<< FRAC_W) + SUMY_W'(my_q) + RND_Y;
  assign r    = R_W'(sumy >>> (2 * FRAC_W));

  always_comb begin
    if (r > NOISE_MAX) begin
      noise_d = NOISE_MAX[NOISE_W-1:0];
    end else if (r < NOISE_MIN) begin
      noise_d = NOISE_MIN[NOISE_W-1:0];
    end else begin
      noise_d = r[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      noise_q <= noise_d;
    end
  end

  assign noise_o = noise_q;

endmodule
